[rtl/rkc_pkg.sv]
// shared types, constants and codes for the 3x3 rgb convolution unit
// no dependencies; imported by rkc_mac and the top level
`default_nettype none

package rkc_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_WIDTH      = 2048;
  localparam int DEF_MAX_HEIGHT     = 2048;
  localparam int DEF_COEF_FRAC_BITS = 12;

  // fixed field widths
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int COEF_W  = 16;
  localparam int KROW_W  = 3 * COEF_W;
  localparam int DIM_W   = 12;
  localparam int PROD_W  = CH_W + 1 + COEF_W;
  localparam int SUM_W   = PROD_W + 4;
  localparam int CFG_IDX_W = 3;

  // result queue
  localparam int OUT_DEPTH = 16;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd4;

  // operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [KROW_W-1:0] KROW_MIDDLE_RESET = 48'h0000_1000_0000;

  typedef struct packed {
    logic            operation;
    logic [CH_W-1:0] pixel_red;
    logic [CH_W-1:0] pixel_green;
    logic [CH_W-1:0] pixel_blue;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            end_of_frame;
  } out_t;

  // window indexed [row][col], rows top..bottom, cols left..right
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    win_t win;
    logic eof;
  } job_t;

  typedef enum logic [2:0] {
    FL_IDLE,
    FL_LEFT,
    FL_MID,
    FL_RIGHT,
    FL_DONE
  } fl_state_e;

endpackage

`default_nettype wire

[rtl/rkc_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rkc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/rkc_mac.sv]
// registered multiply and sum stages, then combinational clamp/round, for one 3x3 window
// depends on rkc_pkg
`default_nettype none

module rkc_mac #(
  parameter int COEF_FRAC_BITS = rkc_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               job_valid_i,
  input  wire rkc_pkg::job_t                      job_i,
  input  wire logic [2:0][rkc_pkg::KROW_W-1:0]    kernel_i,
  output logic                                    res_valid_o,
  output rkc_pkg::out_t                           res_o
);
  import rkc_pkg::*;

  localparam int TOP  = 255 << COEF_FRAC_BITS;
  localparam int HALF = 1 << (COEF_FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_q [3][9];
  logic signed [SUM_W-1:0]  sum_q  [3];
  logic [1:0] vld_q;
  logic [1:0] eof_q;
  logic [CH_W-1:0] ch_res [3];

  // products
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[ch][r*3+c] <=
            $signed({1'b0, job_i.win[r][c][(2-ch)*CH_W +: CH_W]})
            * $signed(kernel_i[r][c*COEF_W +: COEF_W]);
        end
      end
    end
  end

  // channel sums
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_q[ch] <= SUM_W'(prod_q[ch][0]) + SUM_W'(prod_q[ch][1]) + SUM_W'(prod_q[ch][2])
                 + SUM_W'(prod_q[ch][3]) + SUM_W'(prod_q[ch][4]) + SUM_W'(prod_q[ch][5])
                 + SUM_W'(prod_q[ch][6]) + SUM_W'(prod_q[ch][7]) + SUM_W'(prod_q[ch][8]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    eof_q <= {eof_q[0], job_i.eof};
  end

  // clamp to 0..255 then round half up
  always_comb begin
    logic signed [SUM_W-1:0] tmp;
    for (int ch = 0; ch < 3; ch++) begin
      tmp = sum_q[ch] + SUM_W'(HALF);
      if (sum_q[ch] <= 0) begin
        ch_res[ch] = '0;
      end else if (sum_q[ch] >= TOP) begin
        ch_res[ch] = 8'd255;
      end else begin
        ch_res[ch] = tmp[COEF_FRAC_BITS +: CH_W];
      end
    end
  end

  assign res_valid_o        = vld_q[1];
  assign res_o.out_red      = ch_res[0];
  assign res_o.out_green    = ch_res[1];
  assign res_o.out_blue     = ch_res[2];
  assign res_o.end_of_frame = eof_q[1];

endmodule

`default_nettype wire

[rtl/rgb_kernel_convolution_clamp_edge_unit.sv]
// top level of the streaming 3x3 rgb convolution with clamp-to-edge borders
// depends on rkc_pkg, rkc_ram (two line stores) and rkc_mac (filter datapath)
//
//   channel | signals                          | direction | carries
//   --------+----------------------------------+-----------+-----------------------
//   in      | in_valid_i in_ready_o in_data_i  | sink      | pixel or flush request
//   out     | out_valid_o out_ready_i out_data_o | source  | filtered pixel + eof
//   cfg     | cfg_we_i cfg_index_i cfg_data_i  | sink      | register write, no wait
//
// pixel requests are taken one per cycle; a pixel in the last column of a row after
// the first (width of two or more) produces two results and holds off the next request
// a flush request steps through FL_LEFT, FL_MID, FL_RIGHT and FL_DONE: three reads of
// each line store over its single read port (left, center, right column), then the
// window is formed in FL_DONE; a 16 entry result queue with slot reservation at accept
// lets results wait, and requests also stall while fewer than two slots are free or a
// flush is in progress
// reset clears counters and restores the default config; line stores need no clearing
// since every read follows a write of the same frame
`default_nettype none

module rgb_kernel_convolution_clamp_edge_unit #(
  parameter int MAX_WIDTH      = rkc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = rkc_pkg::DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS = rkc_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire rkc_pkg::in_t                      in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output rkc_pkg::out_t                          out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [rkc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rkc_pkg::KROW_W-1:0]        cfg_data_i
);
  import rkc_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // ---------------- configuration ----------------
  logic [DIM_W-1:0]            width_q, height_q;
  logic [2:0][KROW_W-1:0]      kernel_q;
  logic                        restart;

  assign restart = cfg_we_i &&
                   (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= DIM_W'(1);
      height_q    <= DIM_W'(1);
      kernel_q[0] <= '0;
      kernel_q[1] <= KROW_MIDDLE_RESET;
      kernel_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:   width_q     <= cfg_data_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  height_q    <= cfg_data_i[DIM_W-1:0];
        CFG_KERNEL_TOP:    kernel_q[0] <= cfg_data_i;
        CFG_KERNEL_MIDDLE: kernel_q[1] <= cfg_data_i;
        CFG_KERNEL_BOTTOM: kernel_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // last column / row index, zero acts as one, oversize saturates
  logic [31:0]   wl_full, hl_full;
  logic [AW-1:0] w_last;
  logic [HW-1:0] h_last;

  always_comb begin
    if (width_q == '0)                   wl_full = '0;
    else if (32'(width_q) > MAX_WIDTH)   wl_full = 32'(MAX_WIDTH - 1);
    else                                 wl_full = 32'(width_q) - 32'd1;
    if (height_q == '0)                  hl_full = '0;
    else if (32'(height_q) > MAX_HEIGHT) hl_full = 32'(MAX_HEIGHT - 1);
    else                                 hl_full = 32'(height_q) - 32'd1;
  end

  assign w_last = wl_full[AW-1:0];
  assign h_last = hl_full[HW-1:0];

  // ---------------- request accept and position ----------------
  logic [AW-1:0]  col_q;
  logic [HW-1:0]  row_q;
  logic           drain_q;
  logic           accept, pix_go, fl_go, col_last, row_last;
  logic [1:0]     promised;
  fl_state_e      fl_state_q, fl_state_d;
  logic           two_pending;
  logic [OUT_AW:0] used_q;

  assign accept   = in_valid_i && in_ready_o;
  assign pix_go   = accept && (in_data_i.operation == OP_PIXEL) && !drain_q;
  assign fl_go    = accept && (in_data_i.operation == OP_FLUSH) && drain_q;
  assign col_last = (col_q == w_last);
  assign row_last = (row_q == h_last);

  // results this request will produce, reserved in the result queue up front
  always_comb begin
    promised = 2'd0;
    if (pix_go && row_q != '0) begin
      promised = 2'((col_q != '0)) + 2'(col_last);
    end else if (fl_go) begin
      promised = 2'd1;
    end
  end

  assign in_ready_o = (fl_state_q == FL_IDLE) && !two_pending &&
                      (32'(used_q) + 32'd2 <= OUT_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
    end else if (restart) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
    end else if (pix_go) begin
      if (col_last) begin
        col_q <= '0;
        if (row_last) drain_q <= 1'b1;
        else          row_q   <= row_q + HW'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end else if (fl_go) begin
      if (col_last) begin
        col_q   <= '0;
        row_q   <= '0;
        drain_q <= 1'b0;
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // ---------------- stage a: line store read in flight ----------------
  logic              sa_valid_q, sa_row0_q, sa_first_q, sa_last_q;
  logic [PIX_W-1:0]  sa_pix_q;
  logic [AW-1:0]     sa_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sa_valid_q <= 1'b0;
    else         sa_valid_q <= pix_go;
  end

  always_ff @(posedge clk_i) begin
    if (pix_go) begin
      sa_pix_q   <= {in_data_i.pixel_red, in_data_i.pixel_green, in_data_i.pixel_blue};
      sa_col_q   <= col_q;
      sa_row0_q  <= (row_q == '0);
      sa_first_q <= (col_q == '0);
      sa_last_q  <= col_last;
    end
  end

  // last column of a row after the first, with a left neighbour, gives two windows
  assign two_pending = sa_valid_q && !sa_row0_q && !sa_first_q && sa_last_q;

  // ---------------- line stores ----------------
  logic [AW-1:0]    raddr, lft, rgt;
  logic [PIX_W-1:0] old_rdata, new_rdata;
  logic             st_we;
  logic [PIX_W-1:0] old_wdata;
  logic [AW-1:0]    fl_col_q;
  logic             fl_last_q;

  assign lft = (fl_col_q == '0) ? '0 : fl_col_q - AW'(1);
  assign rgt = fl_last_q ? fl_col_q : fl_col_q + AW'(1);

  always_comb begin
    case (fl_state_q)
      FL_LEFT:  raddr = lft;
      FL_MID:   raddr = fl_col_q;
      FL_RIGHT: raddr = rgt;
      default:  raddr = col_q;
    endcase
  end

  rkc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (sa_col_q),
    .wdata_i (old_wdata),
    .raddr_i (raddr),
    .rdata_o (old_rdata)
  );

  rkc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (sa_col_q),
    .wdata_i (sa_pix_q),
    .raddr_i (raddr),
    .rdata_o (new_rdata)
  );

  // ---------------- stage b: window update and write-back ----------------
  // a one-pixel-wide frame reads the entry written in the same cycle, so the
  // last write is forwarded
  logic              fwd_valid_q;
  logic [AW-1:0]     fwd_addr_q;
  logic [PIX_W-1:0]  fwd_old_q, fwd_new_q;
  logic [PIX_W-1:0]  rd_old, rd_new;
  logic              fwd_hit;
  logic [2:0][PIX_W-1:0] colv;
  win_t              win_q, win_d, edge_win;
  logic              job1, job2;

  assign fwd_hit   = fwd_valid_q && (fwd_addr_q == sa_col_q);
  assign rd_old    = fwd_hit ? fwd_old_q : old_rdata;
  assign rd_new    = fwd_hit ? fwd_new_q : new_rdata;
  assign st_we     = sa_valid_q;
  assign old_wdata = sa_row0_q ? sa_pix_q : rd_new;
  assign colv      = {sa_pix_q, rd_new, rd_old};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (sa_first_q) begin
        win_d[r][0] = colv[r];
        win_d[r][1] = colv[r];
      end else begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
      end
      win_d[r][2]    = colv[r];
      edge_win[r][0] = win_d[r][1];
      edge_win[r][1] = win_d[r][2];
      edge_win[r][2] = win_d[r][2];
    end
  end

  assign job1 = sa_valid_q && !sa_row0_q && !sa_first_q;
  assign job2 = sa_valid_q && !sa_row0_q && sa_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fwd_valid_q <= 1'b0;
    else         fwd_valid_q <= st_we;
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= sa_col_q;
    fwd_old_q  <= old_wdata;
    fwd_new_q  <= sa_pix_q;
    if (sa_valid_q && !sa_row0_q) begin
      win_q <= win_d;
    end
  end

  // ---------------- flush sequencer ----------------
  logic [PIX_W-1:0] cap_old_l_q, cap_new_l_q, cap_old_c_q, cap_new_c_q;
  win_t             fl_win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fl_state_q <= FL_IDLE;
    else         fl_state_q <= fl_state_d;
  end

  always_comb begin
    fl_state_d = fl_state_q;
    unique case (fl_state_q)
      FL_IDLE:  if (fl_go) fl_state_d = FL_LEFT;
      FL_LEFT:  fl_state_d = FL_MID;
      FL_MID:   fl_state_d = FL_RIGHT;
      FL_RIGHT: fl_state_d = FL_DONE;
      FL_DONE:  fl_state_d = FL_IDLE;
      default:  fl_state_d = FL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fl_go) begin
      fl_col_q  <= col_q;
      fl_last_q <= col_last;
    end
    if (fl_state_q == FL_MID) begin
      cap_old_l_q <= old_rdata;
      cap_new_l_q <= new_rdata;
    end
    if (fl_state_q == FL_RIGHT) begin
      cap_old_c_q <= old_rdata;
      cap_new_c_q <= new_rdata;
    end
  end

  // bottom row clamps to the last row
  always_comb begin
    fl_win[0] = {old_rdata, cap_old_c_q, cap_old_l_q};
    fl_win[1] = {new_rdata, cap_new_c_q, cap_new_l_q};
    fl_win[2] = {new_rdata, cap_new_c_q, cap_new_l_q};
  end

  // ---------------- filter job select ----------------
  logic  cj_valid_q, pend_valid_q;
  job_t  cj_q, pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cj_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      cj_valid_q   <= job1 || job2 || pend_valid_q || (fl_state_q == FL_DONE);
      pend_valid_q <= job1 && job2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job1) begin
      cj_q <= '{win: win_d, eof: 1'b0};
    end else if (job2) begin
      cj_q <= '{win: edge_win, eof: 1'b0};
    end else if (pend_valid_q) begin
      cj_q <= pend_q;
    end else begin
      cj_q <= '{win: fl_win, eof: fl_last_q};
    end
    pend_q <= '{win: edge_win, eof: 1'b0};
  end

  // ---------------- filter datapath ----------------
  logic res_valid;
  out_t res;

  rkc_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (cj_valid_q),
    .job_i       (cj_q),
    .kernel_i    (kernel_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // ---------------- result queue ----------------
  out_t              fifo_q [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_AW:0]   cnt_q;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      used_q   <= '0;
    end else begin
      if (res_valid) wr_ptr_q <= wr_ptr_q + OUT_AW'(1);
      if (pop)       rd_ptr_q <= rd_ptr_q + OUT_AW'(1);
      cnt_q  <= cnt_q + (OUT_AW+1)'(res_valid) - (OUT_AW+1)'(pop);
      used_q <= used_q + (OUT_AW+1)'(promised) - (OUT_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

endmodule

`default_nettype wire
